>>> sv/yrag_pkg.sv
// shared types and constants of the yuv420 rotation address generator
package yrag_pkg;

   localparam int unsigned CFG_DATA_WIDTH = 32;
   localparam int unsigned CFG_ADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH         = 3'd0,
      REG_FRAME_HEIGHT        = 3'd1,
      REG_ROTATION_QUARTERS   = 3'd2,
      REG_LUMA_ROW_STRIDE     = 3'd3,
      REG_LUMA_PIXEL_STRIDE   = 3'd4,
      REG_CHROMA_ROW_STRIDE   = 3'd5,
      REG_CHROMA_PIXEL_STRIDE = 3'd6,
      REG_NONE                = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [1:0]  rotation_quarters;
      logic [14:0] luma_row_stride;
      logic [2:0]  luma_pixel_stride;
      logic [14:0] chroma_row_stride;
      logic [2:0]  chroma_pixel_stride;
   } cfg_type;

   localparam logic [12:0] FRAME_WIDTH_RESET         = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET        = 13'd480;
   localparam logic [1:0]  ROTATION_QUARTERS_RESET   = 2'd0;
   localparam logic [14:0] LUMA_ROW_STRIDE_RESET     = 15'd640;
   localparam logic [2:0]  LUMA_PIXEL_STRIDE_RESET   = 3'd1;
   localparam logic [14:0] CHROMA_ROW_STRIDE_RESET   = 15'd640;
   localparam logic [2:0]  CHROMA_PIXEL_STRIDE_RESET = 3'd2;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

endpackage

>>> sv/yrag_csr.sv
// configuration register file behind the apb-style port
module yrag_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [yrag_pkg::CFG_ADDR_WIDTH-1:0] paddr,
   input  logic [yrag_pkg::CFG_DATA_WIDTH-1:0] pwdata,
   output logic [yrag_pkg::CFG_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output yrag_pkg::cfg_type                   cfg
);

   yrag_pkg::cfg_type       cfg_ff;
   yrag_pkg::cfg_type       cfg_in;
   yrag_pkg::reg_index_type index;
   logic                    wr_en;

   assign index  = yrag_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            yrag_pkg::REG_FRAME_WIDTH:         cfg_in.frame_width = pwdata[12:0];
            yrag_pkg::REG_FRAME_HEIGHT:        cfg_in.frame_height = pwdata[12:0];
            yrag_pkg::REG_ROTATION_QUARTERS:   cfg_in.rotation_quarters = pwdata[1:0];
            yrag_pkg::REG_LUMA_ROW_STRIDE:     cfg_in.luma_row_stride = pwdata[14:0];
            yrag_pkg::REG_LUMA_PIXEL_STRIDE:   cfg_in.luma_pixel_stride = pwdata[2:0];
            yrag_pkg::REG_CHROMA_ROW_STRIDE:   cfg_in.chroma_row_stride = pwdata[14:0];
            yrag_pkg::REG_CHROMA_PIXEL_STRIDE: cfg_in.chroma_pixel_stride = pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         yrag_pkg::REG_FRAME_WIDTH:         prdata[12:0] = cfg_ff.frame_width;
         yrag_pkg::REG_FRAME_HEIGHT:        prdata[12:0] = cfg_ff.frame_height;
         yrag_pkg::REG_ROTATION_QUARTERS:   prdata[1:0]  = cfg_ff.rotation_quarters;
         yrag_pkg::REG_LUMA_ROW_STRIDE:     prdata[14:0] = cfg_ff.luma_row_stride;
         yrag_pkg::REG_LUMA_PIXEL_STRIDE:   prdata[2:0]  = cfg_ff.luma_pixel_stride;
         yrag_pkg::REG_CHROMA_ROW_STRIDE:   prdata[14:0] = cfg_ff.chroma_row_stride;
         yrag_pkg::REG_CHROMA_PIXEL_STRIDE: prdata[2:0]  = cfg_ff.chroma_pixel_stride;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width         <= yrag_pkg::FRAME_WIDTH_RESET;
         cfg_ff.frame_height        <= yrag_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.rotation_quarters   <= yrag_pkg::ROTATION_QUARTERS_RESET;
         cfg_ff.luma_row_stride     <= yrag_pkg::LUMA_ROW_STRIDE_RESET;
         cfg_ff.luma_pixel_stride   <= yrag_pkg::LUMA_PIXEL_STRIDE_RESET;
         cfg_ff.chroma_row_stride   <= yrag_pkg::CHROMA_ROW_STRIDE_RESET;
         cfg_ff.chroma_pixel_stride <= yrag_pkg::CHROMA_PIXEL_STRIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/yuv420_rotation_address_generator.sv
// top level of the yuv420 rotation address generator
//
// Each req beat names one destination pixel: req_restart high goes back to the
// first pixel of the frame, low moves on to the next in raster order. Every
// req beat yields exactly one rsp beat carrying source and destination luma
// byte offsets, and at even column and even row also the chroma site offsets
// (zero otherwise). rsp_last_pixel marks the final pixel; the walk then wraps.
// Configuration sits behind the apb-style port at byte address 4*index; the
// user is to write it only while the block is idle; the block does not enforce it.
// A beat passes three registers, a position and rotation stage, a
// multiply stage and an add and saturate stage that is the output register.
// A new beat is taken every cycle while req_ready is high; the position
// counter update sets this rate of one beat per cycle.
// When the receiver holds rsp_ready low the stages fill and req_ready drops
// only once every stage holds a beat; no beat is lost or repeated.
// Reset empties the pipeline, sets the position to the first pixel and loads
// the register defaults (640 x 480, no rotation).
module yuv420_rotation_address_generator #(
   parameter int unsigned MAX_DIM    = 4096,
   parameter int unsigned ADDR_WIDTH = 26
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ADDR_WIDTH-1:0]               rsp_src_luma_addr,
   output logic [ADDR_WIDTH-1:0]               rsp_dst_luma_addr,
   output logic                                rsp_chroma_valid,
   output logic [ADDR_WIDTH-1:0]               rsp_src_chroma_addr,
   output logic [ADDR_WIDTH-1:0]               rsp_dst_chroma_addr,
   output logic                                rsp_last_pixel,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [yrag_pkg::CFG_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [yrag_pkg::CFG_DATA_WIDTH-1:0] csr_pwdata,
   output logic [yrag_pkg::CFG_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned CW  = $clog2(MAX_DIM + 1);
   localparam int unsigned PW1 = 2 * CW + 3;
   localparam int unsigned PW2 = CW + 15;
   localparam int unsigned PW  = (PW1 > PW2) ? PW1 : PW2;
   localparam int unsigned SW  = (PW + 1 > ADDR_WIDTH + 1) ? PW + 1 : ADDR_WIDTH + 1;

   yrag_pkg::cfg_type cfg;

   yrag_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic adv1, adv2, adv3, req_fire;

   assign adv3      = ~s3_valid_ff | rsp_ready;
   assign adv2      = ~s2_valid_ff | adv3;
   assign adv1      = ~s1_valid_ff | adv2;
   assign req_ready = adv1;
   assign req_fire  = req_valid & adv1;
   assign rsp_valid = s3_valid_ff;

   // position and rotation
   logic [CW-1:0]   col_ff, col_in, row_ff, row_in;
   logic [CW-1:0]   w, h, dw, dh, dx, dy, sx, sy;
   logic [CW:0]     dx_inc, dy_inc;
   logic            snap, cv, last;
   logic [31:0]     fw32, fh32;

   assign fw32 = 32'(cfg.frame_width);
   assign fh32 = 32'(cfg.frame_height);

   always_comb begin
      priority if (fw32 < 32'd2) begin
         w = CW'(2);
      end else if (fw32 > 32'(MAX_DIM)) begin
         w = CW'(MAX_DIM);
      end else begin
         w = fw32[CW-1:0];
      end
      priority if (fh32 < 32'd2) begin
         h = CW'(2);
      end else if (fh32 > 32'(MAX_DIM)) begin
         h = CW'(MAX_DIM);
      end else begin
         h = fh32[CW-1:0];
      end
   end

   assign dw   = cfg.rotation_quarters[0] ? h : w;
   assign dh   = cfg.rotation_quarters[0] ? w : h;
   assign snap = req_restart | (col_ff >= dw) | (row_ff >= dh);
   assign dx   = snap ? '0 : col_ff;
   assign dy   = snap ? '0 : row_ff;

   always_comb begin
      unique case (cfg.rotation_quarters)
         yrag_pkg::ROT_90: begin
            sx = dy;
            sy = h - CW'(1) - dx;
         end
         yrag_pkg::ROT_180: begin
            sx = w - CW'(1) - dx;
            sy = h - CW'(1) - dy;
         end
         yrag_pkg::ROT_270: begin
            sx = w - CW'(1) - dy;
            sy = dx;
         end
         default: begin
            sx = dx;
            sy = dy;
         end
      endcase
   end

   assign cv     = ~dx[0] & ~dy[0];
   assign last   = (dx == dw - CW'(1)) & (dy == dh - CW'(1));
   assign dx_inc = {1'b0, dx} + (CW + 1)'(1);
   assign dy_inc = {1'b0, dy} + (CW + 1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (dx_inc < {1'b0, dw}) begin
            col_in = dx_inc[CW-1:0];
            row_in = dy;
         end else begin
            col_in = '0;
            row_in = (dy_inc < {1'b0, dh}) ? dy_inc[CW-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 registers
   logic [CW-1:0]   s1_sx_ff, s1_sy_ff, s1_dx_ff, s1_dy_ff;
   logic            s1_cv_ff, s1_last_ff;
   logic [CW+2:0]   s1_lstride_ff;
   logic [CW+1:0]   s1_cstride_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_sx_ff      <= sx;
         s1_sy_ff      <= sy;
         s1_dx_ff      <= dx;
         s1_dy_ff      <= dy;
         s1_cv_ff      <= cv;
         s1_last_ff    <= last;
         s1_lstride_ff <= (CW + 3)'(dw) * (CW + 3)'(cfg.luma_pixel_stride);
         s1_cstride_ff <= (CW + 2)'(dw[CW-1:1]) * (CW + 2)'(cfg.chroma_pixel_stride);
      end
   end

   // stage 2: products
   logic [CW+2:0]    s2_sxl_ff, s2_dxl_ff, s2_sxc_ff, s2_dxc_ff;
   logic [CW+14:0]   s2_syl_ff, s2_syc_ff;
   logic [2*CW+2:0]  s2_dyl_ff;
   logic [2*CW+1:0]  s2_dyc_ff;
   logic             s2_cv_ff, s2_last_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_sxl_ff  <= (CW + 3)'(s1_sx_ff) * (CW + 3)'(cfg.luma_pixel_stride);
         s2_syl_ff  <= (CW + 15)'(s1_sy_ff) * (CW + 15)'(cfg.luma_row_stride);
         s2_dxl_ff  <= (CW + 3)'(s1_dx_ff) * (CW + 3)'(cfg.luma_pixel_stride);
         s2_dyl_ff  <= (2 * CW + 3)'(s1_dy_ff) * (2 * CW + 3)'(s1_lstride_ff);
         s2_sxc_ff  <= (CW + 3)'(s1_sx_ff[CW-1:1]) * (CW + 3)'(cfg.chroma_pixel_stride);
         s2_syc_ff  <= (CW + 15)'(s1_sy_ff[CW-1:1]) * (CW + 15)'(cfg.chroma_row_stride);
         s2_dxc_ff  <= (CW + 3)'(s1_dx_ff[CW-1:1]) * (CW + 3)'(cfg.chroma_pixel_stride);
         s2_dyc_ff  <= (2 * CW + 2)'(s1_dy_ff[CW-1:1]) * (2 * CW + 2)'(s1_cstride_ff);
         s2_cv_ff   <= s1_cv_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // stage 3: sums with saturation
   function automatic logic [ADDR_WIDTH-1:0] sat_addr(input logic [SW-1:0] v);
      logic [ADDR_WIDTH-1:0] res;
      res = (|v[SW-1:ADDR_WIDTH]) ? '1 : v[ADDR_WIDTH-1:0];
      return res;
   endfunction

   logic [SW-1:0] sum_sl, sum_dl, sum_sc, sum_dc;

   assign sum_sl = SW'(s2_sxl_ff) + SW'(s2_syl_ff);
   assign sum_dl = SW'(s2_dxl_ff) + SW'(s2_dyl_ff);
   assign sum_sc = SW'(s2_sxc_ff) + SW'(s2_syc_ff);
   assign sum_dc = SW'(s2_dxc_ff) + SW'(s2_dyc_ff);

   logic [ADDR_WIDTH-1:0] s3_src_luma_ff, s3_dst_luma_ff, s3_src_chroma_ff, s3_dst_chroma_ff;
   logic                  s3_cv_ff, s3_last_ff;

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_src_luma_ff   <= sat_addr(sum_sl);
         s3_dst_luma_ff   <= sat_addr(sum_dl);
         s3_src_chroma_ff <= s2_cv_ff ? sat_addr(sum_sc) : '0;
         s3_dst_chroma_ff <= s2_cv_ff ? sat_addr(sum_dc) : '0;
         s3_cv_ff         <= s2_cv_ff;
         s3_last_ff       <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_src_luma_addr   = s3_src_luma_ff;
   assign rsp_dst_luma_addr   = s3_dst_luma_ff;
   assign rsp_chroma_valid    = s3_cv_ff;
   assign rsp_src_chroma_addr = s3_src_chroma_ff;
   assign rsp_dst_chroma_addr = s3_dst_chroma_ff;
   assign rsp_last_pixel      = s3_last_ff;

endmodule
